// File: rtl/core/palette_voxel_store_unit_defines.svh
// Assertion macros used by the checker file of the voxel store.
`ifndef PALETTE_VOXEL_STORE_UNIT_DEFINES_SVH
`define PALETTE_VOXEL_STORE_UNIT_DEFINES_SVH

// Checked only while reset is released.
`define PVS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define PVS_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// File: rtl/core/pvs_pkg.sv
package pvs_pkg;

    localparam logic [1:0] REQ_READ  = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_FILL  = 2'd2;
    localparam logic [1:0] REQ_RSVD  = 2'd3;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_DMG  = 2'd2;

    // Bit positions of the per-voxel written marks and, but for MK_DMG, of the live array bits.
    localparam int MK_SLOT = 0;
    localparam int MK_DENS = 1;
    localparam int MK_ROT  = 2;
    localparam int MK_FLAG = 3;
    localparam int MK_DMG  = 4;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [14:0] voxel_index;
        logic [15:0] block_id;
        logic [7:0]  density;
        logic [7:0]  damage;
        logic [7:0]  rotation;
        logic [7:0]  flag_bits;
    } t_req;

    typedef struct packed {
        logic [15:0] block_id_out;
        logic [7:0]  density_out;
        logic [7:0]  damage_out;
        logic [7:0]  rotation_out;
        logic [7:0]  flags_out;
        logic        uniform;
        logic [8:0]  distinct_types;
        logic [1:0]  status;
    } t_rsp;

    typedef struct packed {
        logic [7:0] dens;
        logic [7:0] rot;
        logic [7:0] flg;
        logic [7:0] dmg;
    } t_side;

endpackage

// File: rtl/core/pvs_if.sv
interface pvs_req_if import pvs_pkg::*; ();
    logic valid;
    logic ready;
    t_req data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface pvs_rsp_if import pvs_pkg::*; ();
    logic valid;
    logic ready;
    t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: rtl/core/palette_voxel_store_unit.sv
// Channel   Dir  Payload  Request accepted when
// i_req     in   t_req    i_req.valid and i_req.ready at a rising edge
// o_rsp     out  t_rsp    o_rsp.valid and o_rsp.ready at a rising edge
//
// A read passes S_VRD, S_PRD, S_DONE; a write keeping the block id S_VRD, S_PRD,
// S_SIDE, S_DONE; one changing it also scans the used palette slots in S_SCAN and
// picks one in S_PICK. A fill runs S_INIT, then the S_CLR sweep clearing the voxel marks.
// After reset the same sweep runs before the first request.
// One request is in work at a time; a finished result waits in the output register.
// VOXELS must be a power of two.
module palette_voxel_store_unit import pvs_pkg::*; #(
    parameter int VOXELS        = 32768,
    parameter int PALETTE_SLOTS = 256
) (
    input logic       i_clk,
    input logic       i_rst_n,
    pvs_req_if.sink   i_req,
    pvs_rsp_if.source o_rsp
);

    localparam int VA = $clog2(VOXELS);
    localparam int SW = $clog2(PALETTE_SLOTS);
    localparam int LW = $clog2(PALETTE_SLOTS + 1);
    localparam int RW = $clog2(VOXELS + 1);
    localparam int MK_LO = SW + 32;
    localparam int VW = MK_LO + 5;
    localparam int PW = 16 + RW;
    localparam logic [RW-1:0] FULL_REF = RW'(VOXELS);
    localparam logic [LW-1:0] LEN_MAX  = LW'(PALETTE_SLOTS);

    localparam logic [3:0] S_INIT = 4'd0;
    localparam logic [3:0] S_CLR  = 4'd1;
    localparam logic [3:0] S_IDLE = 4'd2;
    localparam logic [3:0] S_VRD  = 4'd3;
    localparam logic [3:0] S_PRD  = 4'd4;
    localparam logic [3:0] S_SCAN = 4'd5;
    localparam logic [3:0] S_PICK = 4'd6;
    localparam logic [3:0] S_SIDE = 4'd7;
    localparam logic [3:0] S_DONE = 4'd8;

    logic [VW-1:0] vox_mem [VOXELS];
    logic [PW-1:0] pal_mem [PALETTE_SLOTS];

    logic [VW-1:0] r_vq;
    logic [PW-1:0] r_pq;
    logic          vox_we;
    logic [VA-1:0] vox_wa, vox_ra;
    logic [VW-1:0] vox_wd;
    logic          pal_we;
    logic [SW-1:0] pal_wa, pal_ra;
    logic [PW-1:0] pal_wd;

    logic [3:0]    r_state, n_state;
    logic [VA-1:0] r_cnt, n_cnt;
    logic          r_fpend, n_fpend;
    logic [VA-1:0] r_idx, n_idx;
    t_req          r_q, n_q;
    logic [VW-1:0] r_word, n_word;
    logic [SW-1:0] r_old, n_old;
    logic [RW-1:0] r_old_ref, n_old_ref;
    logic [15:0]   r_old_id, n_old_id;
    logic          r_dec, n_dec;
    logic [LW-1:0] r_scan, n_scan;
    logic          r_pv, n_pv;
    logic [SW-1:0] r_pidx, n_pidx;
    logic          r_hit, n_hit;
    logic [SW-1:0] r_hit_idx, n_hit_idx;
    logic [RW-1:0] r_hit_ref, n_hit_ref;
    logic          r_free, n_free;
    logic [SW-1:0] r_free_idx, n_free_idx;
    logic [LW-1:0] r_len, n_len;
    logic [LW-1:0] r_dist, n_dist;
    logic [3:0]    r_live, n_live;
    logic [RW-1:0] r_dcnt, n_dcnt;
    logic [7:0]    r_def_dens, n_def_dens;
    logic [7:0]    r_def_rot, n_def_rot;
    logic [7:0]    r_def_flg, n_def_flg;
    logic [15:0]   r_fid, n_fid;
    t_rsp          r_res, n_res;
    logic          r_ov, n_ov;
    t_rsp          r_ob, n_ob;

    logic          accept;
    logic [16:0]   idx_ext;
    logic [VA-1:0] idx_in;
    logic [4:0]    vmk;
    logic [SW-1:0] vslot;
    logic [15:0]   pq_id;
    logic [RW-1:0] pq_ref;
    t_side         eff;
    logic [4:0]    mk;
    t_side         sv;
    logic [SW-1:0] pick;
    logic [RW-1:0] pref;
    logic [15:0]   dist_ext;

    function automatic t_side eff_side(input logic [VW-1:0] w, input logic [7:0] dd,
                                       input logic [7:0] dr, input logic [7:0] df);
        t_side s;
        s = w[31:0];
        if (!w[MK_LO+MK_DENS]) s.dens = dd;
        if (!w[MK_LO+MK_ROT]) s.rot = dr;
        if (!w[MK_LO+MK_FLAG]) s.flg = df;
        if (!w[MK_LO+MK_DMG]) s.dmg = 8'd0;
        return s;
    endfunction

    always_ff @(posedge i_clk) begin
        if (vox_we) begin
            vox_mem[vox_wa] <= vox_wd;
        end
        r_vq <= vox_mem[vox_ra];
    end

    always_ff @(posedge i_clk) begin
        if (pal_we) begin
            pal_mem[pal_wa] <= pal_wd;
        end
        r_pq <= pal_mem[pal_ra];
    end

    assign accept = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE);
    assign o_rsp.valid = r_ov;
    assign o_rsp.data = r_ob;

    assign idx_ext = {2'b00, i_req.data.voxel_index};
    assign idx_in = idx_ext[VA-1:0];
    assign vmk = r_vq[VW-1:MK_LO];
    assign vslot = vmk[MK_SLOT] ? r_vq[MK_LO-1:32] : '0;
    assign pq_id = r_pq[PW-1:RW];
    assign pq_ref = r_pq[RW-1:0];
    assign eff = eff_side(r_word, r_def_dens, r_def_rot, r_def_flg);
    assign dist_ext = 16'(r_dist);

    always_comb begin
        n_state = r_state;   n_cnt = r_cnt;         n_fpend = r_fpend;
        n_idx = r_idx;       n_q = r_q;             n_word = r_word;
        n_old = r_old;       n_old_ref = r_old_ref; n_old_id = r_old_id;
        n_dec = r_dec;       n_scan = r_scan;       n_pv = r_pv;
        n_pidx = r_pidx;     n_hit = r_hit;         n_hit_idx = r_hit_idx;
        n_hit_ref = r_hit_ref;
        n_free = r_free;     n_free_idx = r_free_idx;
        n_len = r_len;       n_dist = r_dist;       n_live = r_live;
        n_dcnt = r_dcnt;     n_def_dens = r_def_dens;
        n_def_rot = r_def_rot;
        n_def_flg = r_def_flg;
        n_fid = r_fid;       n_res = r_res;         n_ov = r_ov;
        n_ob = r_ob;
        vox_we = 1'b0;  vox_wa = r_idx;  vox_wd = r_word;  vox_ra = idx_in;
        pal_we = 1'b0;  pal_wa = r_old;  pal_wd = '0;      pal_ra = r_old;
        mk = r_word[VW-1:MK_LO];
        sv = r_word[31:0];
        pick = '0;
        pref = '0;

        if (r_ov && o_rsp.ready) begin
            n_ov = 1'b0;
        end

        unique case (r_state)
            S_INIT: begin
                pal_we = 1'b1;
                pal_wa = '0;
                pal_wd = {r_fid, FULL_REF};
                n_cnt = '0;
                n_state = S_CLR;
            end
            S_CLR: begin
                vox_we = 1'b1;
                vox_wa = r_cnt;
                vox_wd = '0;
                n_cnt = r_cnt + 1'b1;
                if (&r_cnt) begin
                    n_state = r_fpend ? S_DONE : S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_q = i_req.data;
                    n_idx = idx_in;
                    if (i_req.data.req_type == REQ_FILL) begin
                        n_def_dens = i_req.data.density;
                        n_def_rot = i_req.data.rotation;
                        n_def_flg = i_req.data.flag_bits;
                        n_live = '0;
                        n_dcnt = '0;
                        n_len = LW'(1);
                        n_dist = LW'(1);
                        n_fid = i_req.data.block_id;
                        n_fpend = 1'b1;
                        n_res = '0;
                        n_res.block_id_out = i_req.data.block_id;
                        n_res.density_out = i_req.data.density;
                        n_res.rotation_out = i_req.data.rotation;
                        n_res.flags_out = i_req.data.flag_bits;
                        n_res.status = (i_req.data.damage != 8'd0) ? ST_DMG : ST_OK;
                        n_state = S_INIT;
                    end else begin
                        n_state = S_VRD;
                    end
                end
            end
            S_VRD: begin
                n_word = r_vq;
                n_old = vslot;
                pal_ra = vslot;
                n_state = S_PRD;
            end
            S_PRD: begin
                n_old_id = pq_id;
                n_old_ref = pq_ref;
                if (r_q.req_type != REQ_WRITE) begin
                    n_res = '0;
                    n_res.block_id_out = pq_id;
                    n_res.density_out = eff.dens;
                    n_res.damage_out = eff.dmg;
                    n_res.rotation_out = eff.rot;
                    n_res.flags_out = eff.flg;
                    n_res.status = ST_OK;
                    n_state = S_DONE;
                end else if (pq_id == r_q.block_id) begin
                    n_state = S_SIDE;
                end else begin
                    n_dec = (pq_ref != '0);
                    if (pq_ref != '0) begin
                        pal_we = 1'b1;
                        pal_wd = {pq_id, pq_ref - 1'b1};
                        if (pq_ref == RW'(1)) begin
                            n_dist = r_dist - 1'b1;
                        end
                    end
                    n_scan = '0;
                    n_pv = 1'b0;
                    n_hit = 1'b0;
                    n_free = 1'b0;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                pal_ra = r_scan[SW-1:0];
                n_pv = 1'b0;
                if (r_scan < r_len) begin
                    n_scan = r_scan + 1'b1;
                    n_pv = 1'b1;
                    n_pidx = r_scan[SW-1:0];
                end
                if (r_pv) begin
                    if (pq_id == r_q.block_id && pq_ref != '0) begin
                        n_hit = 1'b1;
                        n_hit_idx = r_pidx;
                        n_hit_ref = pq_ref;
                        n_state = S_PICK;
                    end else if (pq_ref == '0 && !r_free) begin
                        n_free = 1'b1;
                        n_free_idx = r_pidx;
                    end
                end else if (r_scan == r_len) begin
                    n_state = S_PICK;
                end
            end
            S_PICK: begin
                if (r_hit || r_free || r_len < LEN_MAX) begin
                    if (r_hit) begin
                        pick = r_hit_idx;
                        pref = r_hit_ref;
                    end else if (r_free) begin
                        pick = r_free_idx;
                    end else begin
                        pick = r_len[SW-1:0];
                        n_len = r_len + 1'b1;
                    end
                    pal_we = 1'b1;
                    pal_wa = pick;
                    pal_wd = {r_q.block_id, pref + 1'b1};
                    if (pref == '0) begin
                        n_dist = r_dist + 1'b1;
                    end
                    n_live[MK_SLOT] = 1'b1;
                    n_word[MK_LO-1:32] = pick;
                    n_word[MK_LO+MK_SLOT] = 1'b1;
                    n_state = S_SIDE;
                end else begin
                    if (r_dec) begin
                        pal_we = 1'b1;
                        pal_wd = {r_old_id, r_old_ref};
                        if (r_old_ref == RW'(1)) begin
                            n_dist = r_dist + 1'b1;
                        end
                    end
                    n_res = '0;
                    n_res.block_id_out = r_old_id;
                    n_res.density_out = eff.dens;
                    n_res.damage_out = eff.dmg;
                    n_res.rotation_out = eff.rot;
                    n_res.flags_out = eff.flg;
                    n_res.status = ST_FULL;
                    n_state = S_DONE;
                end
            end
            S_SIDE: begin
                if (r_q.density != r_def_dens || r_live[MK_DENS]) begin
                    n_live[MK_DENS] = 1'b1;
                    mk[MK_DENS] = 1'b1;
                    sv.dens = r_q.density;
                end
                if (r_q.rotation != r_def_rot || r_live[MK_ROT]) begin
                    n_live[MK_ROT] = 1'b1;
                    mk[MK_ROT] = 1'b1;
                    sv.rot = r_q.rotation;
                end
                if (r_q.flag_bits != r_def_flg || r_live[MK_FLAG]) begin
                    n_live[MK_FLAG] = 1'b1;
                    mk[MK_FLAG] = 1'b1;
                    sv.flg = r_q.flag_bits;
                end
                if (r_q.damage != 8'd0) begin
                    if (!mk[MK_DMG]) begin
                        n_dcnt = r_dcnt + 1'b1;
                    end
                    mk[MK_DMG] = 1'b1;
                    sv.dmg = r_q.damage;
                end else if (mk[MK_DMG]) begin
                    mk[MK_DMG] = 1'b0;
                    n_dcnt = r_dcnt - 1'b1;
                end
                vox_we = 1'b1;
                vox_wd = {mk, r_word[MK_LO-1:32], sv};
                n_res = '0;
                n_res.block_id_out = r_q.block_id;
                n_res.density_out = mk[MK_DENS] ? sv.dens : r_def_dens;
                n_res.damage_out = mk[MK_DMG] ? sv.dmg : 8'd0;
                n_res.rotation_out = mk[MK_ROT] ? sv.rot : r_def_rot;
                n_res.flags_out = mk[MK_FLAG] ? sv.flg : r_def_flg;
                n_res.status = ST_OK;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_ov || o_rsp.ready) begin
                    n_ov = 1'b1;
                    n_ob = r_res;
                    n_ob.uniform = (r_live == '0) && (r_dcnt == '0);
                    n_ob.distinct_types = (r_dist == '0) ? 9'd1 : dist_ext[8:0];
                    n_fpend = 1'b0;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_fpend <= 1'b0;
            r_fid <= '0;
            r_len <= LW'(1);
            r_dist <= LW'(1);
            r_live <= '0;
            r_dcnt <= '0;
            r_def_dens <= '0;
            r_def_rot <= '0;
            r_def_flg <= '0;
            r_ov <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fpend <= n_fpend;
            r_fid <= n_fid;
            r_len <= n_len;
            r_dist <= n_dist;
            r_live <= n_live;
            r_dcnt <= n_dcnt;
            r_def_dens <= n_def_dens;
            r_def_rot <= n_def_rot;
            r_def_flg <= n_def_flg;
            r_ov <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        r_idx <= n_idx;
        r_q <= n_q;
        r_word <= n_word;
        r_old <= n_old;
        r_old_ref <= n_old_ref;
        r_old_id <= n_old_id;
        r_dec <= n_dec;
        r_scan <= n_scan;
        r_pv <= n_pv;
        r_pidx <= n_pidx;
        r_hit <= n_hit;
        r_hit_idx <= n_hit_idx;
        r_hit_ref <= n_hit_ref;
        r_free <= n_free;
        r_free_idx <= n_free_idx;
        r_res <= n_res;
        r_ob <= n_ob;
    end

endmodule

// File: rtl/core/pvs_checker.sv
`include "palette_voxel_store_unit_defines.svh"

module pvs_checker import pvs_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_req_valid,
    input logic i_req_ready,
    input logic i_rsp_valid,
    input logic i_rsp_ready,
    input t_rsp i_rsp_data
);

    `PVS_ASSERT(a_rsp_hold, i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_data), "Stalled response changed.")
    `PVS_ASSERT(a_one_request, i_req_valid && i_req_ready |=> !i_req_ready, "Second request taken while one is in work.")
    `PVS_ASSERT(a_status_code, i_rsp_valid |-> (i_rsp_data.status == ST_OK || i_rsp_data.status == ST_FULL || i_rsp_data.status == ST_DMG), "Undefined status code.")
    `PVS_ASSERT_RST(a_reset_quiet, !i_rst_n |=> !i_rsp_valid && !i_req_ready, "Block active right after reset.")

endmodule

bind palette_voxel_store_unit pvs_checker u_pvs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp_data  (o_rsp.data)
);
